// File: rtl/core/ps2_host_link_with_fifo_macros.svh
// Assertion macros for the checker file of the PS/2 host link.
`ifndef PS2_HOST_LINK_WITH_FIFO_MACROS_SVH
`define PS2_HOST_LINK_WITH_FIFO_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define PS2HL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ps2hl assertion failed");

// Consequent in the cycle after the antecedent.
`define PS2HL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ps2hl assertion failed");

`endif

// File: rtl/core/ps2hl_pkg.sv
// Types and constants shared by the PS/2 host link modules.
package ps2hl_pkg;

  typedef enum logic [1:0] {
    MODE_EDGE = 2'd0,
    MODE_TICK = 2'd1,
    MODE_POP  = 2'd2,
    MODE_SEND = 2'd3
  } ps2hl_mode_t;

  localparam logic [3:0]  FRAME_BITS    = 4'd11;
  localparam logic [15:0] TIMEOUT_RESET = 16'd250;
  localparam logic [15:0] MS_MAX        = 16'hFFFF;

  typedef struct packed {
    logic       done;
    logic [7:0] data;
  } ps2hl_rx_done_t;

  typedef struct packed {
    logic busy;
    logic drive_low;
    logic ack;
  } ps2hl_tx_stat_t;

endpackage

// File: rtl/core/ps2hl_ifs.sv
// Valid/ready channel interfaces of the PS/2 host link.
interface ps2hl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       data_bit;
  logic [7:0] send_byte;

  modport source (output valid, mode, data_bit, send_byte, input ready);
  modport sink   (input valid, mode, data_bit, send_byte, output ready);
endinterface

interface ps2hl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_valid;
  logic       drive_low;
  logic       tx_busy;
  logic       ack_bit;
  logic [7:0] fifo_count;

  modport source (output valid, rx_byte, rx_valid, drive_low, tx_busy, ack_bit, fifo_count,
                  input ready);
  modport sink   (input valid, rx_byte, rx_valid, drive_low, tx_busy, ack_bit, fifo_count,
                  output ready);
endinterface

interface ps2hl_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/core/ps2hl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ps2hl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/ps2hl_rx.sv
// Receive frame assembler with the inter-edge timeout counter.
module ps2hl_rx (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     edge_ev,
  input  logic                     tick_ev,
  input  logic                     data_bit,
  input  logic [15:0]              timeout,
  output ps2hl_pkg::ps2hl_rx_done_t done_o
);
  import ps2hl_pkg::*;

  logic [3:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] ms_r, ms_nxt;
  logic [3:0]  idx_base, idx_inc;
  logic [7:0]  sh_base, sh_upd;

  always_comb begin
    bit_idx_nxt = bit_idx_r;
    shift_nxt   = shift_r;
    ms_nxt      = ms_r;
    done_o      = '0;
    idx_base    = bit_idx_r;
    sh_base     = shift_r;
    sh_upd      = shift_r;
    idx_inc     = bit_idx_r;
    if (edge_ev) begin
      // A stale partial frame is thrown away before this bit is taken.
      if (ms_r > timeout) begin
        idx_base = '0;
        sh_base  = '0;
      end
      ms_nxt = '0;
      sh_upd = sh_base;
      if (idx_base inside {[4'd1:4'd8]}) begin
        sh_upd[3'(idx_base - 4'd1)] = sh_base[3'(idx_base - 4'd1)] | data_bit;
      end
      idx_inc = idx_base + 4'd1;
      if (idx_inc >= FRAME_BITS) begin
        done_o.done = 1'b1;
        done_o.data = sh_upd;
        bit_idx_nxt = '0;
        shift_nxt   = '0;
      end else begin
        bit_idx_nxt = idx_inc;
        shift_nxt   = sh_upd;
      end
    end else if (tick_ev && (ms_r != MS_MAX)) begin
      ms_nxt = ms_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_idx_r <= '0;
      shift_r   <= '0;
      ms_r      <= '0;
    end else begin
      bit_idx_r <= bit_idx_nxt;
      shift_r   <= shift_nxt;
      ms_r      <= ms_nxt;
    end
  end

endmodule

// File: rtl/core/ps2hl_tx.sv
// Transmit frame sequencer: data, parity, release and acknowledge sampling.
module ps2hl_tx (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     edge_ev,
  input  logic                     start_ev,
  input  logic                     data_bit,
  input  logic [7:0]               send_byte,
  output logic                     busy,
  output ps2hl_pkg::ps2hl_tx_stat_t stat_nxt
);
  import ps2hl_pkg::*;

  logic [3:0] step_r, step_nxt;
  logic [8:0] pattern_r, pattern_nxt;
  logic       drive_r, drive_nxt;
  logic       ack_r, ack_nxt;

  assign busy = (step_r inside {[4'd1:FRAME_BITS]});

  always_comb begin
    step_nxt    = step_r;
    pattern_nxt = pattern_r;
    drive_nxt   = drive_r;
    ack_nxt     = ack_r;
    if (edge_ev && busy) begin
      if (step_r <= 4'd9) begin
        drive_nxt = pattern_r[step_r - 4'd1];
      end else if (step_r == 4'd10) begin
        drive_nxt = 1'b0;
      end
      if (step_r >= FRAME_BITS) begin
        ack_nxt  = data_bit;
        step_nxt = '0;
      end else begin
        step_nxt = step_r + 4'd1;
      end
    end else if (start_ev && !busy) begin
      // The inverted odd parity bit equals the XOR of the data bits.
      pattern_nxt = {^send_byte, ~send_byte};
      step_nxt    = 4'd1;
      drive_nxt   = 1'b1;
      ack_nxt     = 1'b1;
    end
  end

  always_comb begin
    stat_nxt.busy      = (step_nxt inside {[4'd1:FRAME_BITS]});
    stat_nxt.drive_low = drive_nxt;
    stat_nxt.ack       = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      pattern_r <= '0;
      drive_r   <= 1'b0;
      ack_r     <= 1'b1;
    end else begin
      step_r    <= step_nxt;
      pattern_r <= pattern_nxt;
      drive_r   <= drive_nxt;
      ack_r     <= ack_nxt;
    end
  end

endmodule

// File: rtl/core/ps2_host_link_with_fifo.sv
// PS/2 host link top level: event decode, receive FIFO and result register.
// An item's result is registered and appears in the cycle after its beat is accepted.
// Throughput: one item per cycle unless the result beat stalls; a pop reads the FIFO
// RAM through its single registered read port, and the byte written by one beat is
// readable by the next. Reset is synchronous and active low and clears control state;
// the FIFO RAM needs no clearing pass, as only entries between the pointers are read.
module ps2_host_link_with_fifo #(
  parameter int FIFO_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  ps2hl_in_if.sink    in_if,
  ps2hl_out_if.source out_if,
  ps2hl_cfg_if.sink   cfg_if
);
  import ps2hl_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  // The fill level is worked out at least eight bits wide so that the
  // low byte can be reported whatever the depth.
  localparam int FW = (AW > 8) ? AW : 8;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // Configuration register: the frame timeout in milliseconds.
  logic [15:0] timeout_r, timeout_nxt;

  // FIFO pointers; both pre-increment, so the FIFO holds one byte fewer
  // than its depth.
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_inc, rp_inc;

  // Result register, which parts the input side from the output side.
  logic       out_valid_r, out_valid_nxt;
  logic       rx_valid_r, rx_valid_nxt;
  logic       drive_r, drive_nxt;
  logic       busy_r, busy_nxt;
  logic       ack_r, ack_nxt;
  logic [7:0] count_r, count_nxt;

  logic           accept;
  ps2hl_mode_t    mode_w;
  logic           tx_busy_now;
  ps2hl_tx_stat_t tx_stat;
  ps2hl_rx_done_t rx_done;
  logic           ram_we, ram_re;
  logic [7:0]     ram_rdata;
  logic [FW-1:0]  wp_x, rp_x, fill;

  // A new beat is taken whenever the result register is empty or is being
  // emptied in the same cycle.
  assign in_if.ready  = rst_n && (!out_valid_r || out_if.ready);
  assign cfg_if.ready = rst_n;
  assign accept       = in_if.valid && in_if.ready;
  assign mode_w       = ps2hl_mode_t'(in_if.mode);

  assign timeout_nxt = (cfg_if.valid && cfg_if.ready) ? cfg_if.data : timeout_r;

  // Clock edges belong to the transmitter while it is busy, and to the
  // receiver otherwise.
  ps2hl_tx u_tx (
    .clk       (clk),
    .rst_n     (rst_n),
    .edge_ev   (accept && (mode_w == MODE_EDGE)),
    .start_ev  (accept && (mode_w == MODE_SEND)),
    .data_bit  (in_if.data_bit),
    .send_byte (in_if.send_byte),
    .busy      (tx_busy_now),
    .stat_nxt  (tx_stat)
  );

  ps2hl_rx u_rx (
    .clk      (clk),
    .rst_n    (rst_n),
    .edge_ev  (accept && (mode_w == MODE_EDGE) && !tx_busy_now),
    .tick_ev  (accept && (mode_w == MODE_TICK)),
    .data_bit (in_if.data_bit),
    .timeout  (timeout_r),
    .done_o   (rx_done)
  );

  assign wp_inc = ptr_next(wp_r);
  assign rp_inc = ptr_next(rp_r);

  // A finished byte is dropped when the FIFO is full. A pop on an empty
  // FIFO leaves the pointers alone and reports no data.
  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    ram_we = 1'b0;
    ram_re = 1'b0;
    if (rx_done.done && (wp_inc != rp_r)) begin
      wp_nxt = wp_inc;
      ram_we = 1'b1;
    end
    if (accept && (mode_w == MODE_POP) && (rp_r != wp_r)) begin
      rp_nxt = rp_inc;
      ram_re = 1'b1;
    end
  end

  // The read and write never hit the same entry in one cycle: the write
  // goes one place past the newest byte, the read to an older one.
  ps2hl_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_inc),
    .wdata (rx_done.data),
    .re    (ram_re),
    .raddr (rp_inc),
    .rdata (ram_rdata)
  );

  // Fill level after this beat, modulo the depth.
  always_comb begin
    wp_x = FW'(wp_nxt);
    rp_x = FW'(rp_nxt);
    if (wp_nxt >= rp_nxt) begin
      fill = wp_x - rp_x;
    end else begin
      fill = wp_x + FW'(FIFO_DEPTH) - rp_x;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    rx_valid_nxt  = rx_valid_r;
    drive_nxt     = drive_r;
    busy_nxt      = busy_r;
    ack_nxt       = ack_r;
    count_nxt     = count_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      rx_valid_nxt  = ram_re;
      drive_nxt     = tx_stat.drive_low;
      busy_nxt      = tx_stat.busy;
      ack_nxt       = tx_stat.ack;
      count_nxt     = fill[7:0];
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      timeout_r   <= timeout_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rx_valid_r <= rx_valid_nxt;
    drive_r    <= drive_nxt;
    busy_r     <= busy_nxt;
    ack_r      <= ack_nxt;
    count_r    <= count_nxt;
  end

  // The RAM read data holds until the next pop, so it stays put while the
  // result beat is stalled.
  assign out_if.valid      = out_valid_r;
  assign out_if.rx_byte    = rx_valid_r ? ram_rdata : 8'd0;
  assign out_if.rx_valid   = rx_valid_r;
  assign out_if.drive_low  = drive_r;
  assign out_if.tx_busy    = busy_r;
  assign out_if.ack_bit    = ack_r;
  assign out_if.fifo_count = count_r;

endmodule

// File: rtl/core/ps2hl_checker.sv
// Port-level checker for the PS/2 host link, bound to the top level.
`include "ps2_host_link_with_fifo_macros.svh"

module ps2hl_checker (
  input logic         clk,
  input logic         rst_n,
  ps2hl_in_if.sink    in_if,
  ps2hl_out_if.source out_if
);
  import ps2hl_pkg::*;

  // A stalled result beat keeps its byte, its fill count and its drive-low bit.
  `PS2HL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_if.valid && !out_if.ready, out_if.valid && $stable(out_if.rx_byte) && $stable(out_if.fifo_count) && $stable(out_if.drive_low))

  // Every accepted beat yields a result in the next cycle.
  `PS2HL_ASSERT_NEXT(a_result_follows, clk, rst_n, in_if.valid && in_if.ready, out_if.valid)

  // No popped byte means the byte field reads zero.
  `PS2HL_ASSERT_SAME(a_empty_pop_zero, clk, rst_n, out_if.valid && !out_if.rx_valid, out_if.rx_byte == 8'd0)

  // The line is released whenever no transmit frame is running.
  `PS2HL_ASSERT_SAME(a_idle_released, clk, rst_n, out_if.valid && !out_if.tx_busy, !out_if.drive_low)

endmodule

bind ps2_host_link_with_fifo ps2hl_checker u_ps2hl_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_if  (in_if),
  .out_if (out_if)
);
